[design/dcln_pkg.sv]
// ----------------------------------------------------------------------------
// dcln_pkg
// Shared types and constants for the daisy-chained light node.
// ----------------------------------------------------------------------------
`default_nettype none

package dcln_pkg;

  // Packet length in bytes, fixed by the bus protocol
  localparam int unsigned PacketBytes = 4;
  localparam int unsigned CountW      = 3;
  localparam int unsigned IdxW        = 2;

  // Item mode codes
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_END    = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Decode masks
  localparam logic [7:0] RED_MASK   = 8'h3F;
  localparam logic [7:0] GREEN_MASK = 8'h0F;
  localparam logic [7:0] BLUE_MASK  = 8'h03;

  // Per-cell control, broadcast along the chain
  typedef struct packed {
    logic shift_en;
    logic load_en;
  } dcln_cell_ctrl_t;

endpackage

`default_nettype wire

[design/dcln_cell.sv]
// ----------------------------------------------------------------------------
// dcln_cell
// One byte slot of the node: a delay-line byte and an own-packet byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dcln_cell
  import dcln_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dcln_cell_ctrl_t ctrl,
  input  wire logic [7:0]      dly_in,
  input  wire logic [7:0]      load_byte,
  output logic      [7:0]      dly_q,
  output logic      [7:0]      dly_nxt,
  output logic      [7:0]      own_nxt
);

  logic [7:0] dly_r;
  logic [7:0] own_r;

  // Advance the delay byte on a shift, take the new packet byte on a load
  always_comb begin
    dly_nxt = ctrl.shift_en ? dly_in : dly_r;
    own_nxt = ctrl.load_en ? load_byte : own_r;
  end

  // Hold both bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= '0;
      own_r <= '0;
    end else begin
      dly_r <= dly_nxt;
      own_r <= own_nxt;
    end
  end

  assign dly_q = dly_r;

endmodule

`default_nettype wire

[design/daisy_chain_led_node_unit.sv]
// ----------------------------------------------------------------------------
// daisy_chain_led_node_unit
// Daisy-chained bus node: own packet out, four-byte forward, RGB latch.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle; its result appears in the output
// register on the cycle after acceptance. The state sits in a row of four
// byte cells, each holding one delay-line byte and one own-packet byte, and
// the delay line advances one cell per received byte. Input stalls only
// while a result is held by a stalled output.
`default_nettype none

module daisy_chain_led_node_unit
  import dcln_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [9:0]  in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_tx_byte,
  output logic      [9:0]  out_red,
  output logic      [9:0]  out_green,
  output logic      [9:0]  out_blue,
  output logic             out_colour_update
);

  logic                 accept;
  dcln_cell_ctrl_t      ctrl;
  logic [7:0]           dly_in   [PacketBytes];
  logic [7:0]           load_b   [PacketBytes];
  logic [7:0]           dly_q    [PacketBytes];
  logic [7:0]           dly_nxt  [PacketBytes];
  logic [7:0]           own_nxt  [PacketBytes];

  logic [CountW-1:0]    seen_r, seen_nxt;
  logic                 out_valid_r;
  logic [7:0]           tx_r, tx_nxt;
  logic [9:0]           red_r, red_nxt;
  logic [9:0]           green_r, green_nxt;
  logic [9:0]           blue_r, blue_nxt;
  logic                 upd_r, upd_nxt;

  // Take a transaction whenever the output slot is free or being emptied
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Decode the mode into cell controls
  always_comb begin
    ctrl.shift_en = accept && (in_mode == MODE_BYTE);
    ctrl.load_en  = accept && (in_mode == MODE_SAMPLE);
  end

  // Feed the chain: received byte into the first cell, packet bytes as loads
  always_comb begin
    for (int i = 0; i < PacketBytes; i++) begin
      dly_in[i] = (i == 0) ? in_rx_byte : dly_q[(i == 0) ? 0 : i - 1];
      load_b[i] = 8'h00;
    end
    load_b[0] = {6'b0, in_sample[9:8]};
    load_b[1] = in_sample[7:0];
  end

  for (genvar g = 0; g < PacketBytes; g++) begin : g_cell
    dcln_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .dly_in    (dly_in[g]),
      .load_byte (load_b[g]),
      .dly_q     (dly_q[g]),
      .dly_nxt   (dly_nxt[g]),
      .own_nxt   (own_nxt[g])
    );
  end

  // Count bytes of the transaction, saturating at the packet length
  always_comb begin
    seen_nxt = seen_r;
    if (accept) begin
      unique case (in_mode)
        MODE_BYTE: begin
          if (seen_r < CountW'(PacketBytes)) seen_nxt = seen_r + CountW'(1);
        end
        MODE_END,
        MODE_SAMPLE: seen_nxt = '0;
        default:     seen_nxt = seen_r;
      endcase
    end
  end

  // Latch colours at transaction end and pick the next outgoing byte
  always_comb begin
    upd_nxt   = accept && (in_mode == MODE_END) && (seen_r != '0);
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    if (upd_nxt) begin
      red_nxt   = {dly_q[3][5:0] & RED_MASK[5:0], dly_q[2][7:4]};
      green_nxt = {dly_q[2][3:0] & GREEN_MASK[3:0], dly_q[1][7:2]};
      blue_nxt  = {dly_q[1][1:0] & BLUE_MASK[1:0], dly_q[0]};
    end
    if (seen_nxt < CountW'(PacketBytes)) tx_nxt = own_nxt[seen_nxt[IdxW-1:0]];
    else                                  tx_nxt = dly_nxt[PacketBytes-1];
  end

  // Hold the count, the colours and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      tx_r        <= '0;
      upd_r       <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        tx_r        <= tx_nxt;
        red_r       <= red_nxt;
        green_r     <= green_nxt;
        blue_r      <= blue_nxt;
        upd_r       <= upd_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = tx_r;
  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_colour_update = upd_r;

endmodule

`default_nettype wire
